>>> hdl/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES-256 package
// Shared types, constants and byte-level functions for the AES-256 core.
// ----------------------------------------------------------------------------
`default_nettype none

package aes_pkg;

    localparam int ROUND_COUNT = 14;
    localparam int KEY_REG_COUNT = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_255_192 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_191_128 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_127_64  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_63_0    = 2'd3;

    typedef logic [127:0] t_block;
    typedef logic [255:0] t_key;

    typedef struct packed {
        logic [63:0] plain_high;
        logic [63:0] plain_low;
        logic        last_block;
    } t_in_item;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
        logic        last_out;
    } t_out_item;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // Byte i of the block lives at bits [127-8i -: 8].
    function automatic t_block sub_shift(input t_block s);
        t_block o;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                o[127-8*(r+4*c) -: 8] = SBOX[s[127-8*(r+4*((c+r)%4)) -: 8]];
            end
        end
        return o;
    endfunction

    function automatic t_block mix_columns(input t_block s);
        t_block o;
        logic [7:0] a0, a1, a2, a3, all;
        for (int c = 0; c < 4; c++) begin
            a0  = s[127-32*c -: 8];
            a1  = s[119-32*c -: 8];
            a2  = s[111-32*c -: 8];
            a3  = s[103-32*c -: 8];
            all = a0 ^ a1 ^ a2 ^ a3;
            o[127-32*c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
            o[119-32*c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
            o[111-32*c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
            o[103-32*c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
        end
        return o;
    endfunction

endpackage

`default_nettype wire

>>> hdl/aes_stream_if.sv
// ----------------------------------------------------------------------------
// AES stream interface
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
`default_nettype none

interface aes_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/aes256_ecb_encrypt_core.sv
// ----------------------------------------------------------------------------
// AES-256 ECB encryption core
// Fully unrolled fourteen-round pipeline with an on-chip key expander.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                   handshake
//  s_in      in   plain_high[64] plain_low[64] last_block   valid/ready
//  m_out     out  cipher_high[64] cipher_low[64] last_out   valid/ready
//  config    in   i_cfg_we, i_cfg_idx[2], i_cfg_data[64]    write only
//
// One item enters per cycle unless the output stalls or the key schedule is not
// ready. Each passes through 15 register stages: the initial key XOR and one per
// round. After reset or the last key write the input stays blocked while the
// schedule is rebuilt: a start pulse requests the expansion, the key is loaded
// as round keys 0 and 1, and round keys 2 to 14 are then computed. A stall at
// the output freezes the whole pipeline, so no item is dropped or repeated.
// Reset clears the valid bits and the key registers.
// ----------------------------------------------------------------------------
`default_nettype none

module aes256_ecb_encrypt_core import aes_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [63:0]          i_cfg_data,
    aes_stream_if.sink                s_in,
    aes_stream_if.source              m_out
);

    localparam int STAGES = ROUND_COUNT + 1;

    logic [63:0] r_key [KEY_REG_COUNT];
    logic        r_sched_ready;
    logic        r_start;
    logic        ks_busy;
    t_block      rk [ROUND_COUNT+1];

    // Key registers; any write invalidates the schedule.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < KEY_REG_COUNT; i++) begin
                r_key[i] <= '0;
            end
            r_sched_ready <= 1'b0;
            r_start       <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_KEY_255_192: r_key[0] <= i_cfg_data;
                    REG_KEY_191_128: r_key[1] <= i_cfg_data;
                    REG_KEY_127_64:  r_key[2] <= i_cfg_data;
                    REG_KEY_63_0:    r_key[3] <= i_cfg_data;
                    default: ;
                endcase
                r_sched_ready <= 1'b0;
            end else if (!r_sched_ready && !r_start && !ks_busy) begin
                r_start       <= 1'b1;
                r_sched_ready <= 1'b1;
            end
        end
    end

    aes_key_sched u_sched (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_key   ({r_key[0], r_key[1], r_key[2], r_key[3]}),
        .o_busy  (ks_busy),
        .o_rk    (rk)
    );

    // Pipeline: stage 0 holds the whitened block, stage r the state after round r.
    logic   r_vld  [STAGES];
    t_block r_st   [STAGES];
    logic   r_last [STAGES];
    logic   advance;
    logic   key_ok;

    assign key_ok  = r_sched_ready && !r_start && !ks_busy;
    assign advance = !r_vld[STAGES-1] || m_out.ready;
    assign s_in.ready = advance && key_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < STAGES; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (advance) begin
            r_vld[0] <= s_in.valid && key_ok;
            for (int i = 1; i < STAGES; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_st[0]   <= {s_in.data.plain_high, s_in.data.plain_low} ^ rk[0];
            r_last[0] <= s_in.data.last_block;
            for (int i = 1; i < STAGES; i++) begin
                if (i == ROUND_COUNT) begin
                    r_st[i] <= sub_shift(r_st[i-1]) ^ rk[i];
                end else begin
                    r_st[i] <= mix_columns(sub_shift(r_st[i-1])) ^ rk[i];
                end
                r_last[i] <= r_last[i-1];
            end
        end
    end

    assign m_out.valid            = r_vld[STAGES-1];
    assign m_out.data.cipher_high = r_st[STAGES-1][127:64];
    assign m_out.data.cipher_low  = r_st[STAGES-1][63:0];
    assign m_out.data.last_out    = r_last[STAGES-1];

    // The input is never taken while the key schedule is being rebuilt.
    a_no_accept_in_expand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ks_busy |-> !s_in.ready) else $error("item accepted during key expansion");

    // A stalled output holds its item.
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_out.valid && !m_out.ready) |=> (m_out.valid && $stable(m_out.data)))
        else $error("output item changed while stalled");

    // A key write always forces a fresh expansion.
    a_write_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !r_sched_ready) else $error("schedule still ready after key write");

endmodule

`default_nettype wire

>>> hdl/aes_key_sched.sv
// ----------------------------------------------------------------------------
// AES-256 key schedule
// Expands the 256-bit key one 128-bit round key per cycle into a register file.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_key_sched import aes_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_start,
    input  wire t_key   i_key,
    output logic        o_busy,
    output t_block      o_rk [ROUND_COUNT+1]
);

    localparam int CNT_W = $clog2(ROUND_COUNT + 1);

    logic [CNT_W-1:0] r_idx;
    logic             r_busy;
    logic [255:0]     r_win;   // last eight words w[i-8..i-1]
    logic [7:0]       r_rc;
    t_block           r_rk [ROUND_COUNT+1];

    logic [31:0] w0, w1, w2, w3, t0, t4;
    t_block      n_key;

    // Every other round key uses RotWord+rcon, the others plain SubWord.
    always_comb begin
        t0 = sub_word({r_win[23:0], r_win[31:24]}) ^ {r_rc, 24'h0};
        t4 = sub_word(r_win[31:0]);
        if (!r_idx[0]) begin
            w0 = r_win[255:224] ^ t0;
        end else begin
            w0 = r_win[255:224] ^ t4;
        end
        w1 = r_win[223:192] ^ w0;
        w2 = r_win[191:160] ^ w1;
        w3 = r_win[159:128] ^ w2;
        n_key = {w0, w1, w2, w3};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_idx  <= CNT_W'(2);
            r_win  <= i_key;
            r_rc   <= 8'h01;
            r_rk[0] <= i_key[255:128];
            r_rk[1] <= i_key[127:0];
        end else if (r_busy) begin
            r_rk[r_idx] <= n_key;
            r_win <= {r_win[127:0], n_key};
            if (!r_idx[0]) begin
                r_rc <= xtime(r_rc);
            end
            if (r_idx == CNT_W'(ROUND_COUNT)) begin
                r_busy <= 1'b0;
            end
            r_idx <= r_idx + CNT_W'(1);
        end
    end

    assign o_busy = r_busy;
    assign o_rk   = r_rk;

endmodule

`default_nettype wire

>>> tb/aes256_ecb_encrypt_core_checker.sv
// ----------------------------------------------------------------------------
// AES-256 ECB checker
// Watches the plaintext and ciphertext channels, predicts each ciphertext
// from its own key schedule and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module aes256_ecb_encrypt_core_checker import aes_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_data,
    aes_stream_if.sink       s_in,
    aes_stream_if.sink       s_out,
    output int               o_fail_count,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [63:0] key_shadow [KEY_REG_COUNT];
    logic [127:0] round_keys [ROUND_COUNT+1];
    bit sched_valid;
    t_out_item cipher_queue [$];

    function automatic logic [7:0] gmul2(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // S-box computed from first principles: inverse in GF(2^8), then affine.
    function automatic logic [7:0] sbox_calc(input logic [7:0] x);
        logic [7:0] inv, base, a, b, p;
        inv = 8'h01;
        base = x;
        for (int e = 0; e < 8; e++) begin
            if (e != 0) begin
                a = inv; b = base; p = 8'h00;
                for (int k = 0; k < 8; k++) begin
                    if (b[0]) p ^= a;
                    a = gmul2(a); b = b >> 1;
                end
                inv = p;
            end
            a = base; b = base; p = 8'h00;
            for (int k = 0; k < 8; k++) begin
                if (b[0]) p ^= a;
                a = gmul2(a); b = b >> 1;
            end
            base = p;
        end
        // The loop yields x^(2+4+...+128) = x^254; x=0 maps to 0 naturally.
        return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^
               {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
    endfunction

    function automatic void expand_schedule();
        logic [31:0] w [4*(ROUND_COUNT+1)];
        logic [31:0] t;
        logic [7:0] rc;
        rc = 8'h01;
        for (int i = 0; i < 8; i++) w[i] = key_shadow[i/2][63-32*(i%2) -: 32];
        for (int i = 8; i < 4*(ROUND_COUNT+1); i++) begin
            t = w[i-1];
            if (i % 8 == 0) begin
                t = {sbox_calc(t[23:16]) ^ rc, sbox_calc(t[15:8]),
                     sbox_calc(t[7:0]), sbox_calc(t[31:24])};
                rc = gmul2(rc);
            end else if (i % 8 == 4) begin
                t = {sbox_calc(t[31:24]), sbox_calc(t[23:16]),
                     sbox_calc(t[15:8]), sbox_calc(t[7:0])};
            end
            w[i] = w[i-8] ^ t;
        end
        for (int r = 0; r <= ROUND_COUNT; r++)
            round_keys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
        sched_valid = 1'b1;
    endfunction

    function automatic logic [127:0] encrypt_block(input logic [127:0] pt);
        logic [127:0] s, o;
        logic [7:0] a0, a1, a2, a3, all;
        s = pt ^ round_keys[0];
        for (int r = 1; r <= ROUND_COUNT; r++) begin
            for (int c = 0; c < 4; c++)
                for (int q = 0; q < 4; q++)
                    o[127-8*(q+4*c) -: 8] = sbox_calc(s[127-8*(q+4*((c+q)%4)) -: 8]);
            s = o;
            if (r != ROUND_COUNT) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = s[127-32*c -: 8]; a1 = s[119-32*c -: 8];
                    a2 = s[111-32*c -: 8]; a3 = s[103-32*c -: 8];
                    all = a0 ^ a1 ^ a2 ^ a3;
                    o[127-32*c -: 8] = a0 ^ all ^ gmul2(a0 ^ a1);
                    o[119-32*c -: 8] = a1 ^ all ^ gmul2(a1 ^ a2);
                    o[111-32*c -: 8] = a2 ^ all ^ gmul2(a2 ^ a3);
                    o[103-32*c -: 8] = a3 ^ all ^ gmul2(a3 ^ a0);
                end
                s = o;
            end
            s ^= round_keys[r];
        end
        return s;
    endfunction

    assign o_pending = cipher_queue.size();

    always @(posedge i_clk) begin
        t_out_item exp_item, got;
        logic [127:0] ct;
        if (!i_rst_n) begin
            for (int i = 0; i < KEY_REG_COUNT; i++) key_shadow[i] = '0;
            sched_valid = 1'b0;
            cipher_queue.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                key_shadow[i_cfg_idx] = i_cfg_data;
                sched_valid = 1'b0;
            end
            if (s_in.valid && s_in.ready) begin
                if (!sched_valid) expand_schedule();
                ct = encrypt_block({s_in.data.plain_high, s_in.data.plain_low});
                exp_item.cipher_high = ct[127:64];
                exp_item.cipher_low = ct[63:0];
                exp_item.last_out = s_in.data.last_block;
                cipher_queue.push_back(exp_item);
            end
            if (s_out.valid && s_out.ready) begin
                got = s_out.data;
                if (cipher_queue.size() == 0) begin
                    $error("ciphertext item with nothing expected: %h", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_item = cipher_queue.pop_front();
                    if (got.cipher_high !== exp_item.cipher_high ||
                        got.cipher_low !== exp_item.cipher_low ||
                        got.last_out !== exp_item.last_out)
                        o_fail_count <= o_fail_count + 1;
                    if (got.cipher_high !== exp_item.cipher_high)
                        $error("cipher_high expected %h actual %h",
                               exp_item.cipher_high, got.cipher_high);
                    if (got.cipher_low !== exp_item.cipher_low)
                        $error("cipher_low expected %h actual %h",
                               exp_item.cipher_low, got.cipher_low);
                    if (got.last_out !== exp_item.last_out)
                        $error("last_out expected %b actual %b",
                               exp_item.last_out, got.last_out);
                end
            end
        end
    end
endmodule

`default_nettype wire

>>> tb/aes256_ecb_encrypt_core_test.sv
// ----------------------------------------------------------------------------
// AES-256 ECB core testbench
// Drives plaintext items under several key settings and idling patterns;
// the checker predicts and compares every ciphertext item.
// ----------------------------------------------------------------------------
`default_nettype none

module aes256_ecb_encrypt_core_test;
    import aes_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;
    int          fail_count;
    int          pending;

    // Percent chances that the sender idles and the receiver stalls.
    int send_idle_pct;
    int recv_stall_pct;

    aes_stream_if #(.T(t_in_item))  plain_ch ();
    aes_stream_if #(.T(t_out_item)) cipher_ch ();

    aes256_ecb_encrypt_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_in       (plain_ch.sink),
        .m_out      (cipher_ch.source)
    );

    aes256_ecb_encrypt_core_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .s_in         (plain_ch.sink),
        .s_out        (cipher_ch.sink),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // The receiver stalls independently of the sender, at the current rate.
    always @(posedge i_clk) begin
        cipher_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Writes one key register; only called while the core is idle.
    task automatic write_key(input logic [1:0] idx, input logic [63:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic load_key(input logic [255:0] key);
        write_key(REG_KEY_255_192, key[255:192]);
        write_key(REG_KEY_191_128, key[191:128]);
        write_key(REG_KEY_127_64,  key[127:64]);
        write_key(REG_KEY_63_0,    key[63:0]);
    endtask

    // Presents one plaintext item and holds it until it is accepted. The
    // valid line stays high between back-to-back items.
    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
                              input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            plain_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        plain_ch.valid           <= 1'b1;
        plain_ch.data.plain_high <= hi;
        plain_ch.data.plain_low  <= lo;
        plain_ch.data.last_block <= last;
        @(posedge i_clk);
        while (!plain_ch.ready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        plain_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        // Allow the pipeline to settle past its own latency.
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic random_blocks(input int count);
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(3))
                0: send_block('0, rand64(), 1'($urandom_range(1)));
                1: send_block(rand64(), '1, 1'($urandom_range(1)));
                default: send_block(rand64(), rand64(), 1'($urandom_range(1)));
            endcase
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        plain_ch.valid  = 1'b0;
        plain_ch.data   = '0;
        cipher_ch.ready = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Before any key write the all-zero reset key must be in use.
        send_block('0, '0, 1'b0);
        send_block('1, '1, 1'b1);
        send_block(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 1'b0);
        drain_results();

        // Standard known-answer vector for the 256-bit key.
        load_key(256'h000102030405060708090a0b0c0d0e0f_101112131415161718191a1b1c1d1e1f);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
        send_block('0, '1, 1'b0);
        send_block('1, '0, 1'b1);
        for (int b = 0; b < 16; b++)
            send_block(64'h1 << (4 * b), 64'h8000_0000_0000_0000 >> (4 * b), b[0]);
        drain_results();

        // All-ones key, then a single register changed to force a new schedule.
        load_key('1);
        send_block('0, '0, 1'b0);
        send_block('1, '1, 1'b1);
        drain_results();
        write_key(REG_KEY_127_64, 64'h0123_4567_89ab_cdef);
        send_block(64'hdead_beef_0000_0001, 64'h0, 1'b1);
        drain_results();

        // Random phases: each takes a fresh key and an idling pattern.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            if (ph == 4) load_key('0);
            else load_key({rand64(), rand64(), rand64(), rand64()});
            random_blocks(100);
            // Hold off the sender until the pipeline empties, then resume.
            drain_results();
            random_blocks(100);
            drain_results();
        end

        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

`default_nettype wire
